// ===== src/ascc_pkg.sv =====
// Shared types and constants for the ADC supply/current conditioner.
`default_nettype none
package ascc_pkg;

    // Event kinds handed from the front end to the back end
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_VOLT,
        KIND_CUR
    } t_kind;

    // Widest ADC sample the event queue carries
    localparam int VAL_W = 12;

    typedef struct packed {
        logic             chan;   // 0 voltage, 1 current
        t_kind            kind;
        logic [VAL_W-1:0] value;  // group average
    } t_evt;

    // Result field widths and limits; tdata carries all fields but the sampled channel
    localparam int VOLT_W     = 6;
    localparam int CUR_W      = 14;
    localparam int DUTY_W     = 11;
    localparam int VOLT_MAX   = (1 << VOLT_W) - 1;
    localparam int CUR_MAX    = (1 << CUR_W) - 1;
    localparam int CUR_SHIFT  = 4;
    localparam int DUTY_SHIFT = 3;
    localparam int FIELDS_W   = 2 + VOLT_W + 1 + CUR_W + 1 + DUTY_W;
    localparam int OUT_DATA_W = ((FIELDS_W + 7) / 8) * 8;
    localparam int PAD_W      = OUT_DATA_W - FIELDS_W;

    // Constant dividers for the voltage scale: reciprocal times 2^RCP_SHIFT
    localparam int DIV_A     = 28;
    localparam int DIV_B     = 55;
    localparam int RCP_SHIFT = 16;
    localparam int RCP_A     = (1 << RCP_SHIFT) / DIV_A;
    localparam int RCP_B     = (1 << RCP_SHIFT) / DIV_B;

    // Configuration register map
    localparam int CFG_IDX_W = 8;
    localparam int CFG_W     = 14;
    localparam logic [CFG_IDX_W-1:0] REG_OC_LIMIT   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STALL_BASE = 8'd1;
    localparam logic [CFG_W-1:0] OC_LIMIT_RST   = 14'd8000;
    localparam logic [CFG_W-1:0] STALL_BASE_RST = 14'd4000;

    // Event queue depth
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

endpackage
`default_nettype wire

// ===== src/ascc_front.sv =====
// Front end: channel tracking, group sums, and event classification.
`default_nettype none
module ascc_front #(
    parameter int ADC_BITS      = 10,
    parameter int VOLT_AVG_LOG2 = 4,
    parameter int CUR_AVG_LOG2  = 2
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic [ADC_BITS-1:0] i_sample,
    output logic                     o_ready,
    input  wire logic                i_full,
    output logic                     o_push,
    output ascc_pkg::t_evt           o_evt
);

    localparam int VS_W = ADC_BITS + VOLT_AVG_LOG2;
    localparam int CS_W = ADC_BITS + CUR_AVG_LOG2;

    logic                     r_on_cur, n_on_cur;
    logic [VS_W-1:0]          r_vsum, n_vsum;
    logic [VOLT_AVG_LOG2-1:0] r_vcnt, n_vcnt;
    logic [CS_W-1:0]          r_csum, n_csum;
    logic [CUR_AVG_LOG2-1:0]  r_ccnt, n_ccnt;

    logic                     w_acc;
    logic [VS_W-1:0]          w_vadd;
    logic [CS_W-1:0]          w_cadd;

    assign o_ready = !i_full;
    assign w_acc   = i_valid && !i_full;
    assign o_push  = w_acc;
    assign w_vadd  = r_vsum + VS_W'(i_sample);
    assign w_cadd  = r_csum + CS_W'(i_sample);

    // Classify the beat and advance the group counters
    always_comb begin
        n_on_cur    = r_on_cur;
        n_vsum      = r_vsum;
        n_vcnt      = r_vcnt;
        n_csum      = r_csum;
        n_ccnt      = r_ccnt;
        o_evt.chan  = r_on_cur;
        o_evt.kind  = ascc_pkg::KIND_NONE;
        o_evt.value = '0;
        if (!r_on_cur) begin
            if (&r_vcnt) begin
                o_evt.kind  = ascc_pkg::KIND_VOLT;
                o_evt.value = ascc_pkg::VAL_W'(w_vadd[VS_W-1:VOLT_AVG_LOG2]);
                n_vsum      = '0;
                n_vcnt      = '0;
            end else begin
                n_vsum = w_vadd;
                n_vcnt = r_vcnt + 1'b1;
            end
        end else begin
            if (&r_ccnt) begin
                o_evt.kind  = ascc_pkg::KIND_CUR;
                o_evt.value = ascc_pkg::VAL_W'(w_cadd[CS_W-1:CUR_AVG_LOG2]);
                n_csum      = '0;
                n_ccnt      = '0;
            end else begin
                n_csum = w_cadd;
                n_ccnt = r_ccnt + 1'b1;
            end
        end
        n_on_cur = !r_on_cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_cur <= 1'b0;
            r_vsum   <= '0;
            r_vcnt   <= '0;
            r_csum   <= '0;
            r_ccnt   <= '0;
        end else if (w_acc) begin
            r_on_cur <= n_on_cur;
            r_vsum   <= n_vsum;
            r_vcnt   <= n_vcnt;
            r_csum   <= n_csum;
            r_ccnt   <= n_ccnt;
        end
    end

endmodule
`default_nettype wire

// ===== src/ascc_queue.sv =====
// Short event queue between front end and back end.
`default_nettype none
module ascc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ascc_pkg::t_evt i_evt,
    output logic                o_full,
    output logic                o_valid,
    input  wire logic           i_pop,
    output ascc_pkg::t_evt      o_evt
);

    localparam int AW = ascc_pkg::Q_AW;

    ascc_pkg::t_evt r_mem [ascc_pkg::Q_DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [AW:0]    r_count;
    logic           w_wr;
    logic           w_rd;

    assign o_full  = (r_count == (AW+1)'(ascc_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;
    assign o_evt   = r_mem[r_rd_ptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_evt;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_rd) r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== src/ascc_back.sv =====
// Back end: block slots, trimmed mean, voltage scale, limit check, output register.
`default_nettype none
module ascc_back #(
    parameter int ADC_BITS = 10
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    input  wire ascc_pkg::t_evt                   i_evt,
    output logic                                  o_pop,
    input  wire logic [ascc_pkg::CFG_W-1:0]       i_oc_limit,
    input  wire logic [ascc_pkg::CFG_W-1:0]       i_stall_base,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic                                  o_chan,
    output logic                                  o_vrdy,
    output logic [ascc_pkg::VOLT_W-1:0]           o_volt,
    output logic                                  o_crdy,
    output logic [ascc_pkg::CUR_W-1:0]            o_cur,
    output logic                                  o_over,
    output logic [ascc_pkg::DUTY_W-1:0]           o_duty
);

    localparam int PW = ADC_BITS + ascc_pkg::RCP_SHIFT;
    localparam int XW = ADC_BITS + ascc_pkg::CUR_SHIFT;

    // Block slots and slot pointer
    logic [ADC_BITS-1:0] r_blk [4];
    logic [1:0]          r_slot;

    // Stage 1 registers
    logic                r_s1_valid;
    logic                r_s1_chan;
    logic                r_s1_vrdy;
    logic                r_s1_crdy;
    logic [ADC_BITS-1:0] r_s1_avg;
    logic [ADC_BITS-1:0] r_s1_qa;
    logic [ADC_BITS-1:0] r_s1_qb;
    logic [ADC_BITS-1:0] r_s1_mean;

    // Output registers
    logic                            r_o_valid;
    logic                            r_o_chan;
    logic                            r_o_vrdy;
    logic [ascc_pkg::VOLT_W-1:0]     r_held_v, n_held_v;
    logic                            r_o_crdy;
    logic [ascc_pkg::CUR_W-1:0]      r_held_c, n_held_c;
    logic                            r_o_over, n_o_over;
    logic [ascc_pkg::DUTY_W-1:0]     r_o_duty, n_o_duty;

    logic                o_rdy;
    logic                s1_rdy;
    logic                w_take;
    logic [ADC_BITS-1:0] w_val;
    logic                w_is_cur;
    logic                w_is_volt;
    logic                w_last_slot;

    logic [ADC_BITS-1:0] w_set [4];
    logic [1:0]          w_hi;
    logic [1:0]          w_lo;
    logic [ADC_BITS:0]   w_acc;
    logic [ADC_BITS-1:0] w_mean;
    logic [PW-1:0]       w_pa;
    logic [PW-1:0]       w_pb;

    logic [ADC_BITS-1:0] w_ma, w_mb, w_ra, w_rb, w_qa, w_qb;
    logic [ADC_BITS:0]   w_vsum;
    logic [XW-1:0]       w_cext;
    logic [ascc_pkg::CUR_W-1:0] w_csat;
    logic [ascc_pkg::CUR_W-1:0] w_cdiff;

    assign o_rdy       = !r_o_valid || i_ready;
    assign s1_rdy      = !r_s1_valid || o_rdy;
    assign w_take      = i_valid && s1_rdy;
    assign o_pop       = w_take;
    assign w_val       = i_evt.value[ADC_BITS-1:0];
    assign w_is_cur    = (i_evt.kind == ascc_pkg::KIND_CUR);
    assign w_is_volt   = (i_evt.kind == ascc_pkg::KIND_VOLT);
    assign w_last_slot = (r_slot == 2'd3);

    // Candidate set: three stored slots plus the block arriving in slot 3
    assign w_set[0] = r_blk[0];
    assign w_set[1] = r_blk[1];
    assign w_set[2] = r_blk[2];
    assign w_set[3] = w_val;

    // Trimmed mean: drop first max and first min, average the rest
    always_comb begin
        w_hi  = 2'd0;
        w_lo  = 2'd0;
        w_acc = '0;
        for (int k = 1; k < 4; k++) begin
            if (w_set[k] > w_set[w_hi]) w_hi = 2'(k);
            if (w_set[k] < w_set[w_lo]) w_lo = 2'(k);
        end
        for (int k = 0; k < 4; k++) begin
            if (2'(k) != w_hi && 2'(k) != w_lo) w_acc = w_acc + (ADC_BITS+1)'(w_set[k]);
        end
        if (w_hi == w_lo) begin
            w_mean = w_set[0];
        end else begin
            w_mean = w_acc[ADC_BITS:1];
        end
    end

    // Reciprocal estimates of avg/28 and avg/55, low by at most one
    assign w_pa = PW'(w_val) * PW'(ascc_pkg::RCP_A);
    assign w_pb = PW'(w_val) * PW'(ascc_pkg::RCP_B);

    // Slot storage
    always_ff @(posedge i_clk) begin
        if (w_take && w_is_cur) begin
            r_blk[r_slot] <= w_val;
        end
    end

    // Stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (w_take && w_is_cur) r_slot <= r_slot + 1'b1;
            if (s1_rdy) r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s1_chan <= i_evt.chan;
            r_s1_vrdy <= w_is_volt;
            r_s1_crdy <= w_is_cur && w_last_slot;
            r_s1_avg  <= w_val;
            r_s1_qa   <= w_pa[PW-1:ascc_pkg::RCP_SHIFT];
            r_s1_qb   <= w_pb[PW-1:ascc_pkg::RCP_SHIFT];
            r_s1_mean <= w_mean;
        end
    end

    // Quotient correction and voltage saturation
    assign w_ma   = ADC_BITS'(r_s1_qa * ADC_BITS'(ascc_pkg::DIV_A));
    assign w_mb   = ADC_BITS'(r_s1_qb * ADC_BITS'(ascc_pkg::DIV_B));
    assign w_ra   = r_s1_avg - w_ma;
    assign w_rb   = r_s1_avg - w_mb;
    assign w_qa   = r_s1_qa + ADC_BITS'(w_ra >= ADC_BITS'(ascc_pkg::DIV_A));
    assign w_qb   = r_s1_qb + ADC_BITS'(w_rb >= ADC_BITS'(ascc_pkg::DIV_B));
    assign w_vsum = (ADC_BITS+1)'(w_qa) + (ADC_BITS+1)'(w_qb);

    // Current scaling, limit check and duty reduction
    assign w_cext  = XW'(r_s1_mean) << ascc_pkg::CUR_SHIFT;
    assign w_csat  = (w_cext > XW'(ascc_pkg::CUR_MAX)) ? ascc_pkg::CUR_W'(ascc_pkg::CUR_MAX)
                                                       : ascc_pkg::CUR_W'(w_cext);
    assign w_cdiff = w_csat - i_stall_base;

    always_comb begin
        n_held_v = r_held_v;
        n_held_c = r_held_c;
        n_o_over = 1'b0;
        n_o_duty = '0;
        if (r_s1_vrdy) begin
            n_held_v = (w_vsum > (ADC_BITS+1)'(ascc_pkg::VOLT_MAX))
                     ? ascc_pkg::VOLT_W'(ascc_pkg::VOLT_MAX) : ascc_pkg::VOLT_W'(w_vsum);
        end
        if (r_s1_crdy) begin
            n_held_c = w_csat;
            if (w_csat > i_oc_limit) begin
                n_o_over = 1'b1;
                if (w_csat > i_stall_base) begin
                    n_o_duty = w_cdiff[ascc_pkg::CUR_W-1:ascc_pkg::DUTY_SHIFT];
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_held_v  <= '0;
            r_held_c  <= '0;
        end else if (o_rdy) begin
            r_o_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_held_v <= n_held_v;
                r_held_c <= n_held_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && r_s1_valid) begin
            r_o_chan <= r_s1_chan;
            r_o_vrdy <= r_s1_vrdy;
            r_o_crdy <= r_s1_crdy;
            r_o_over <= n_o_over;
            r_o_duty <= n_o_duty;
        end
    end

    assign o_valid = r_o_valid;
    assign o_chan  = r_o_chan;
    assign o_vrdy  = r_o_vrdy;
    assign o_volt  = r_held_v;
    assign o_crdy  = r_o_crdy;
    assign o_cur   = r_held_c;
    assign o_over  = r_o_over;
    assign o_duty  = r_o_duty;

endmodule
`default_nettype wire

// ===== src/adc_supply_current_conditioner_core.sv =====
// Top level of the ADC supply-voltage and motor-current conditioner.
//
//  channel  direction  signals                          beat carries
//  s        in         i_s_tvalid/o_s_tready/i_s_tdata  adc_sample in [ADC_BITS-1:0]
//  m        out        o_m_tvalid/i_m_tready/o_m_tdata  conditioned result, tuser = channel
//  cfg      in         i_cfg_valid/o_cfg_ready          register index and 14-bit value
//
//  One sample per cycle while the event queue is not full; o_m_tvalid for a sample rises
//  after its queue write, the trimmed-mean/reciprocal stage and the output register.
//  Synchronous active-low reset clears counters, queue and held values; slots need no clear.
//  A four-deep event queue decouples intake from the result side; intake stalls only
//  when the queue is full, and the back end stalls only on o_m_tvalid without i_m_tready.
`default_nettype none
module adc_supply_current_conditioner_core #(
    parameter int ADC_BITS      = 10,
    parameter int VOLT_AVG_LOG2 = 4,
    parameter int CUR_AVG_LOG2  = 2
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // adc_sample from bit 0
    input  wire logic                                  i_s_tvalid,
    output logic                                       o_s_tready,
    input  wire logic [((ADC_BITS+7)/8)*8-1:0]         i_s_tdata,
    // next_channel, voltage_ready, supply_voltage, current_ready, motor_current,
    // overcurrent, duty_reduction from bit 0, zero padded
    output logic                                       o_m_tvalid,
    input  wire logic                                  i_m_tready,
    output logic [ascc_pkg::OUT_DATA_W-1:0]            o_m_tdata,
    // sampled_channel
    output logic [0:0]                                 o_m_tuser,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [ascc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [ascc_pkg::CFG_W-1:0]            i_cfg_data
);

    logic [ascc_pkg::CFG_W-1:0] r_oc_limit;
    logic [ascc_pkg::CFG_W-1:0] r_stall_base;

    ascc_pkg::t_evt w_push_evt;
    ascc_pkg::t_evt w_pop_evt;
    logic           w_push;
    logic           w_full;
    logic           w_q_valid;
    logic           w_pop;

    logic                          w_chan;
    logic                          w_vrdy;
    logic [ascc_pkg::VOLT_W-1:0]   w_volt;
    logic                          w_crdy;
    logic [ascc_pkg::CUR_W-1:0]    w_cur;
    logic                          w_over;
    logic [ascc_pkg::DUTY_W-1:0]   w_duty;

    // Configuration registers; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oc_limit   <= ascc_pkg::OC_LIMIT_RST;
            r_stall_base <= ascc_pkg::STALL_BASE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ascc_pkg::REG_OC_LIMIT:   r_oc_limit   <= i_cfg_data;
                ascc_pkg::REG_STALL_BASE: r_stall_base <= i_cfg_data;
                default:                  ;
            endcase
        end
    end

    ascc_front #(
        .ADC_BITS      (ADC_BITS),
        .VOLT_AVG_LOG2 (VOLT_AVG_LOG2),
        .CUR_AVG_LOG2  (CUR_AVG_LOG2)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_sample (i_s_tdata[ADC_BITS-1:0]),
        .o_ready  (o_s_tready),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_evt    (w_push_evt)
    );

    ascc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_evt   (w_push_evt),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_evt   (w_pop_evt)
    );

    ascc_back #(
        .ADC_BITS (ADC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_q_valid),
        .i_evt        (w_pop_evt),
        .o_pop        (w_pop),
        .i_oc_limit   (r_oc_limit),
        .i_stall_base (r_stall_base),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_chan       (w_chan),
        .o_vrdy       (w_vrdy),
        .o_volt       (w_volt),
        .o_crdy       (w_crdy),
        .o_cur        (w_cur),
        .o_over       (w_over),
        .o_duty       (w_duty)
    );

    // Result beat packing
    assign o_m_tuser = w_chan;
    assign o_m_tdata = {{ascc_pkg::PAD_W{1'b0}}, w_duty, w_over, w_cur, w_crdy,
                        w_volt, w_vrdy, !w_chan};

endmodule
`default_nettype wire

// ===== test/tb_adc_supply_current_conditioner_core.sv =====
// Self-checking testbench for the ADC supply-voltage / motor-current conditioner core.
`timescale 1ns / 100ps
module tb_adc_supply_current_conditioner_core;

    localparam int ADC_BITS      = 10;
    localparam int VOLT_AVG_LOG2 = 4;
    localparam int CUR_AVG_LOG2  = 2;
    localparam int S_DATA_W      = ((ADC_BITS + 7) / 8) * 8;
    localparam int VOLT_GROUP    = 1 << VOLT_AVG_LOG2;
    localparam int CUR_GROUP     = 1 << CUR_AVG_LOG2;
    localparam int NUM_SLOTS     = 4;
    localparam int SMP_MAX       = (1 << ADC_BITS) - 1;

    // Result beat layout in o_m_tdata, lowest field first
    localparam int OFS_NEXT = 0;
    localparam int OFS_VRDY = 1;
    localparam int OFS_VOLT = 2;
    localparam int OFS_CRDY = OFS_VOLT + ascc_pkg::VOLT_W;
    localparam int OFS_CUR  = OFS_CRDY + 1;
    localparam int OFS_OVER = OFS_CUR + ascc_pkg::CUR_W;
    localparam int OFS_DUTY = OFS_OVER + 1;

    // Channel codes and indexes outside the register map
    localparam logic CH_VOLT = 1'b0;
    localparam logic CH_CUR  = 1'b1;
    localparam logic [ascc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 8'd2;
    localparam logic [ascc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 8'hFF;

    // Run shape
    localparam int NUM_PHASES      = 8;
    localparam int PHASE_ITEMS     = 128;
    localparam int PRESSURE_PHASE  = 4;
    localparam int HOLD_CYCLES     = 200;
    localparam int TAIL_CYCLES     = 8;
    localparam int KEEP_CFG        = -2;
    localparam int RAND_CFG        = -1;
    localparam int TYPED_ROWS      = 4;
    localparam int DIRECTED_ITEMS  = 24;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;
    typedef enum int {FRAME_FLAT, FRAME_TWO_LEVEL, FRAME_SPREAD, FRAME_HIGH, FRAME_NOISE}
        t_frame_mode;

    typedef struct packed {
        logic                        sampled_channel;
        logic                        next_channel;
        logic                        voltage_ready;
        logic [ascc_pkg::VOLT_W-1:0] supply_voltage;
        logic                        current_ready;
        logic [ascc_pkg::CUR_W-1:0]  motor_current;
        logic                        overcurrent;
        logic [ascc_pkg::DUTY_W-1:0] duty_reduction;
    } t_cond_result;

    // Directed samples: extremes and alternating bit patterns on both channels
    localparam logic [ADC_BITS-1:0] DIRECTED_SAMPLES [DIRECTED_ITEMS] = '{
        10'd0,    10'd1023, 10'd1023, 10'd0,
        10'h155,  10'h2AA,  10'h2AA,  10'h155,
        10'd1,    10'd512,  10'd1022, 10'd511,
        10'd1023, 10'd1023, 10'd1023, 10'd1023,
        10'd0,    10'd0,    10'h3F0,  10'h00F,
        10'h200,  10'h001,  10'h0FF,  10'h300
    };

    // Per-phase register settings
    localparam int PH_LIMIT [NUM_PHASES] = '{KEEP_CFG, 0, 16383, 1000, RAND_CFG, 8000,
                                             RAND_CFG, 2000};
    localparam int PH_STALL [NUM_PHASES] = '{KEEP_CFG, 0, 16383, 16383, RAND_CFG, 4000,
                                             RAND_CFG, 0};

    logic                              i_clk;
    logic                              i_rst_n     = 1'b0;
    logic                              i_s_tvalid  = 1'b0;
    logic                              o_s_tready;
    logic [S_DATA_W-1:0]               i_s_tdata   = '0;
    logic                              o_m_tvalid;
    logic                              i_m_tready  = 1'b0;
    logic [ascc_pkg::OUT_DATA_W-1:0]   o_m_tdata;  // next_channel, voltage_ready,
                                                   // supply_voltage, current_ready,
                                                   // motor_current, overcurrent,
                                                   // duty_reduction
    logic [0:0]                        o_m_tuser;  // sampled_channel
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [ascc_pkg::CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [ascc_pkg::CFG_W-1:0]        i_cfg_data  = '0;

    adc_supply_current_conditioner_core #(
        .ADC_BITS      (ADC_BITS),
        .VOLT_AVG_LOG2 (VOLT_AVG_LOG2),
        .CUR_AVG_LOG2  (CUR_AVG_LOG2)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor state
    logic                        on_cur_chan;
    int unsigned                 volt_acc, volt_cnt, cur_acc, cur_cnt, slot_idx;
    int unsigned                 slot_avg [NUM_SLOTS];
    logic [ascc_pkg::VOLT_W-1:0] held_volt;
    logic [ascc_pkg::CUR_W-1:0]  held_cur;
    logic [ascc_pkg::CFG_W-1:0]  cfg_oc_limit, cfg_stall_base;

    // Stimulus shaping state
    t_frame_mode         frame_mode = FRAME_NOISE;
    int unsigned         volt_level;
    int unsigned         slot_level [NUM_SLOTS];

    t_cond_result        pending_results [$];
    int                  fail_count   = 0;
    int unsigned         tx_idle_pct  = 0;
    int unsigned         rx_stall_pct = 0;
    bit                  hold_req     = 1'b0;
    int                  hold_count   = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // Expected beat for one accepted sample; advances the predictor state
    task automatic predict_sample(input logic [ADC_BITS-1:0] smp, output t_cond_result r);
        int unsigned avg, scaled, hi, lo, acc;
        r = '0;
        r.sampled_channel = on_cur_chan;
        if (on_cur_chan == CH_VOLT) begin
            volt_acc += smp;
            volt_cnt++;
            if (volt_cnt >= VOLT_GROUP) begin
                avg       = volt_acc >> VOLT_AVG_LOG2;
                scaled    = avg / ascc_pkg::DIV_A + avg / ascc_pkg::DIV_B;
                held_volt = ascc_pkg::VOLT_W'((scaled > ascc_pkg::VOLT_MAX)
                                              ? ascc_pkg::VOLT_MAX : scaled);
                volt_acc  = 0;
                volt_cnt  = 0;
                r.voltage_ready = 1'b1;
            end
            on_cur_chan = CH_CUR;
        end else begin
            cur_acc += smp;
            cur_cnt++;
            if (cur_cnt >= CUR_GROUP) begin
                slot_avg[slot_idx] = cur_acc >> CUR_AVG_LOG2;
                cur_acc = 0;
                cur_cnt = 0;
                slot_idx++;
                if (slot_idx >= NUM_SLOTS) begin
                    // trimmed mean: drop first max and first min
                    hi = 0;
                    lo = 0;
                    for (int k = 1; k < NUM_SLOTS; k++) begin
                        if (slot_avg[k] > slot_avg[hi]) hi = k;
                        if (slot_avg[k] < slot_avg[lo]) lo = k;
                    end
                    if (hi == lo) begin
                        acc = slot_avg[0];
                    end else begin
                        acc = 0;
                        for (int k = 0; k < NUM_SLOTS; k++)
                            if (k != hi && k != lo) acc += slot_avg[k];
                        acc = acc / (NUM_SLOTS - 2);
                    end
                    acc      = acc << ascc_pkg::CUR_SHIFT;
                    held_cur = ascc_pkg::CUR_W'((acc > ascc_pkg::CUR_MAX)
                                                ? ascc_pkg::CUR_MAX : acc);
                    slot_idx = 0;
                    r.current_ready = 1'b1;
                    if (held_cur > cfg_oc_limit) begin
                        r.overcurrent = 1'b1;
                        if (held_cur > cfg_stall_base)
                            r.duty_reduction = ascc_pkg::DUTY_W'(
                                (held_cur - cfg_stall_base) >> ascc_pkg::DUTY_SHIFT);
                    end
                end
            end
            on_cur_chan = CH_VOLT;
        end
        r.next_channel   = on_cur_chan;
        r.supply_voltage = held_volt;
        r.motor_current  = held_cur;
    endtask

    function automatic t_cond_result make_result(logic sch, logic nch, logic vrdy,
                                                 int unsigned volt, logic crdy,
                                                 int unsigned cur, logic over,
                                                 int unsigned duty);
        t_cond_result r;
        r = '{sch, nch, vrdy, ascc_pkg::VOLT_W'(volt), crdy, ascc_pkg::CUR_W'(cur), over,
              ascc_pkg::DUTY_W'(duty)};
        return r;
    endfunction

    // Random sample shaped by where the predictor is in its groups
    task automatic pick_sample(output logic [ADC_BITS-1:0] smp);
        int unsigned lvl_a, lvl_b;
        if (on_cur_chan == CH_VOLT) begin
            if (volt_cnt == 0) begin
                case ($urandom_range(4))
                    0:       volt_level = 0;
                    1:       volt_level = SMP_MAX;
                    default: volt_level = $urandom_range(SMP_MAX);
                endcase
            end
            smp = ADC_BITS'(($urandom_range(3) == 0) ? $urandom_range(SMP_MAX) : volt_level);
        end else begin
            // new current frame at the start of slot 0
            if (slot_idx == 0 && cur_cnt == 0) begin
                frame_mode = t_frame_mode'($urandom_range(FRAME_NOISE));
                lvl_a = $urandom_range(SMP_MAX);
                lvl_b = $urandom_range(SMP_MAX);
                for (int k = 0; k < NUM_SLOTS; k++) begin
                    case (frame_mode)
                        FRAME_FLAT:      slot_level[k] = lvl_a;
                        FRAME_TWO_LEVEL: slot_level[k] = $urandom_range(1) ? lvl_a : lvl_b;
                        FRAME_HIGH:      slot_level[k] = $urandom_range(SMP_MAX, 600);
                        default:         slot_level[k] = $urandom_range(SMP_MAX);
                    endcase
                end
            end
            smp = ADC_BITS'((frame_mode == FRAME_NOISE) ? $urandom_range(SMP_MAX)
                                                        : slot_level[slot_idx]);
        end
    endtask

    // Offer one sample, wait until it is accepted, queue the expected result
    task automatic feed_sample(input logic [ADC_BITS-1:0] smp, input bit typed,
                               input t_cond_result typed_res);
        t_cond_result predicted;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= S_DATA_W'(smp);
        do @(posedge i_clk); while (!o_s_tready);
        predict_sample(smp, predicted);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic write_reg(input logic [ascc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ascc_pkg::CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            ascc_pkg::REG_OC_LIMIT:   cfg_oc_limit   = val;
            ascc_pkg::REG_STALL_BASE: cfg_stall_base = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Result side ready: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req && hold_count < HOLD_CYCLES) begin
            i_m_tready <= 1'b0;
            hold_count++;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Compare every result beat with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_cond_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no expectation pending");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("sampled_channel", want.sampled_channel, o_m_tuser[0]);
                check_field("next_channel", want.next_channel, o_m_tdata[OFS_NEXT]);
                check_field("voltage_ready", want.voltage_ready, o_m_tdata[OFS_VRDY]);
                check_field("supply_voltage", want.supply_voltage,
                            o_m_tdata[OFS_VOLT +: ascc_pkg::VOLT_W]);
                check_field("current_ready", want.current_ready, o_m_tdata[OFS_CRDY]);
                check_field("motor_current", want.motor_current,
                            o_m_tdata[OFS_CUR +: ascc_pkg::CUR_W]);
                check_field("overcurrent", want.overcurrent, o_m_tdata[OFS_OVER]);
                check_field("duty_reduction", want.duty_reduction,
                            o_m_tdata[OFS_DUTY +: ascc_pkg::DUTY_W]);
            end
        end
    end

    // Main stimulus
    initial begin
        t_cond_result         typed_expect [TYPED_ROWS];
        logic [ADC_BITS-1:0]  smp;
        t_idle_mode           mode;

        on_cur_chan    = CH_VOLT;
        volt_acc       = 0;
        volt_cnt       = 0;
        cur_acc        = 0;
        cur_cnt        = 0;
        slot_idx       = 0;
        held_volt      = '0;
        held_cur       = '0;
        cfg_oc_limit   = ascc_pkg::OC_LIMIT_RST;
        cfg_stall_base = ascc_pkg::STALL_BASE_RST;
        for (int k = 0; k < NUM_SLOTS; k++) slot_avg[k] = 0;

        // first beats after reset: channels alternate, nothing held yet
        typed_expect[0] = make_result(CH_VOLT, CH_CUR, 0, 0, 0, 0, 0, 0);
        typed_expect[1] = make_result(CH_CUR, CH_VOLT, 0, 0, 0, 0, 0, 0);
        typed_expect[2] = make_result(CH_VOLT, CH_CUR, 0, 0, 0, 0, 0, 0);
        typed_expect[3] = make_result(CH_CUR, CH_VOLT, 0, 0, 0, 0, 0, 0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // writes outside the register map must leave the limits alone
        write_reg(REG_UNMAPPED_LO, ascc_pkg::CFG_W'(ascc_pkg::CUR_MAX));
        write_reg(REG_UNMAPPED_HI, '0);
        i_cfg_valid <= 1'b0;

        // directed table
        for (int i = 0; i < DIRECTED_ITEMS; i++)
            feed_sample(DIRECTED_SAMPLES[i], i < TYPED_ROWS,
                        typed_expect[i < TYPED_ROWS ? i : 0]);

        // random phases; each sets its limits and idling pattern, but phase 0 keeps the limits
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            if (PH_LIMIT[p] != KEEP_CFG) begin
                write_reg(ascc_pkg::REG_OC_LIMIT, (PH_LIMIT[p] == RAND_CFG) ?
                          ascc_pkg::CFG_W'($urandom_range(ascc_pkg::CUR_MAX)) :
                          ascc_pkg::CFG_W'(PH_LIMIT[p]));
                write_reg(ascc_pkg::REG_STALL_BASE, (PH_STALL[p] == RAND_CFG) ?
                          ascc_pkg::CFG_W'($urandom_range(ascc_pkg::CUR_MAX)) :
                          ascc_pkg::CFG_W'(PH_STALL[p]));
                i_cfg_valid <= 1'b0;
            end
            mode = t_idle_mode'(p % 4);
            tx_idle_pct  = (mode == IDLE_SENDER)   ? 79 : (mode == IDLE_BOTH) ? 12 : 0;
            rx_stall_pct = (mode == IDLE_RECEIVER) ? 79 : (mode == IDLE_BOTH) ? 12 : 0;
            // long result-side hold-off while samples keep coming
            if (p == PRESSURE_PHASE) hold_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                pick_sample(smp);
                feed_sample(smp, 1'b0, typed_expect[0]);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
